### rtl/core/mrpt_pkg.sv
package mrpt_pkg;

    localparam int PAGE_W = 52;
    localparam int ADDR_W = 64;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_P2V  = 2'd1;
    localparam logic [1:0] KIND_V2P  = 2'd2;
    localparam logic [1:0] KIND_NEXT = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SKIPPED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_NEXT   = 3'd4;

    localparam logic [ADDR_W-1:0] LOW_MEMORY_END = 64'h0000_0000_0010_0000;
    localparam logic [12:0]       PAGE_BYTES     = 13'h1000;
    localparam logic [52:0]       LOW_PAGE_LIMIT = 53'h100;
    localparam logic [7:0]        TYPE_USABLE    = 8'd1;
    localparam int                PAGE_SHIFT     = 12;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] base_address;
        logic [ADDR_W-1:0] region_bytes;
        logic [7:0]        region_type;
        logic [PAGE_W-1:0] page;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        logic [2:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] length;
    } entry_t;

endpackage

### rtl/core/memory_region_page_translator_unit.sv
// Region table with a packed virtual page space. The table lives in a ring of
// MAX_REGIONS cells; a request that walks the table turns the ring once, one
// region passing the head cell per cycle, while a sequencer inspects the head
// and, for an add, splices the new region in through a one-entry hold
// register. A walking request presents its result once the ring has turned;
// an add that is filtered or finds the table full presents it from the
// preparation state without walking. One request is in flight at a time.
module memory_region_page_translator_unit
    import mrpt_pkg::*;
#(
    parameter int MAX_REGIONS = 256
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_REGIONS - 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_REGIONS - 1);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_WALK, S_DONE} state_t;

    state_t            state_reg;
    req_t              req_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     idx_reg;
    entry_t            new_reg;
    entry_t            hold_reg;
    logic              ins_reg;
    logic              done_reg;
    logic              want_reg;
    logic [PAGE_W-1:0] acc_reg;
    logic [PAGE_W-1:0] res_reg;
    logic [2:0]        st_reg;

    entry_t ring [MAX_REGIONS];
    entry_t head;
    entry_t tail;
    logic   shift_en;

    // Ring of cells: each cell loads from the next, the last from the tail.
    for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
        entry_t d_k;
        if (k == MAX_REGIONS - 1) begin : g_tail
            assign d_k = tail;
        end else begin : g_mid
            assign d_k = ring[k+1];
        end
        mrpt_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d_in     (d_k),
            .q        (ring[k])
        );
    end

    assign head     = ring[0];
    assign shift_en = (state_reg == S_WALK);

    // Head-cell view for the current step.
    logic              valid_c;
    logic              at_end_c;
    logic              ins_now;
    logic [PAGE_W:0]   end_c;
    assign valid_c  = (CW'(idx_reg) < count_reg);
    assign at_end_c = (CW'(idx_reg) == count_reg);
    assign end_c    = {1'b0, head.start} + {1'b0, head.length};
    assign ins_now  = (req_reg.kind == KIND_ADD) && !ins_reg &&
                      ((valid_c && head.start > new_reg.start) || at_end_c);

    // Splice: the new region enters at the tail and later regions slip by one.
    always_comb begin
        if (ins_now) begin
            tail = new_reg;
        end else if (ins_reg) begin
            tail = hold_reg;
        end else begin
            tail = head;
        end
    end

    // Normalization of an added region.
    logic [ADDR_W-1:0] base_c;
    logic [ADDR_W-1:0] bytes_c;
    logic [11:0]       off_c;
    logic [ADDR_W-1:0] shard_c;
    logic [ADDR_W-1:0] len_c;
    logic [52:0]       start_c;
    logic [ADDR_W-1:0] len_pg_c;
    logic              skip_c;
    entry_t            norm_c;
    always_comb begin
        base_c   = req_reg.base_address;
        bytes_c  = req_reg.region_bytes;
        off_c    = base_c[11:0];
        shard_c  = ADDR_W'(PAGE_BYTES - {1'b0, off_c});
        skip_c   = (req_reg.region_type != TYPE_USABLE) ||
                   (base_c < LOW_MEMORY_END && bytes_c <= LOW_MEMORY_END - base_c);
        start_c  = {1'b0, base_c[ADDR_W-1:PAGE_SHIFT]};
        len_c    = bytes_c;
        if (off_c != 12'd0) begin
            if (bytes_c <= shard_c) begin
                skip_c = 1'b1;
            end
            len_c   = bytes_c - shard_c;
            start_c = start_c + 53'd1;
        end
        len_pg_c = len_c >> PAGE_SHIFT;
        if (start_c <= LOW_PAGE_LIMIT) begin
            len_pg_c = len_pg_c + ADDR_W'(start_c);
            start_c  = '0;
        end
        norm_c.start  = start_c[PAGE_W-1:0];
        norm_c.length = len_pg_c[PAGE_W-1:0];
    end

    // Sequencer with registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ins_reg   <= 1'b0;
            done_reg  <= 1'b0;
            want_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    idx_reg  <= '0;
                    ins_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    want_reg <= 1'b0;
                    acc_reg  <= '0;
                    res_reg  <= '0;
                    new_reg  <= norm_c;
                    st_reg   <= ST_NOT_FOUND;
                    if (req_reg.kind == KIND_ADD) begin
                        if (count_reg >= FULL_COUNT) begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end else if (skip_c) begin
                            st_reg    <= ST_SKIPPED;
                            state_reg <= S_DONE;
                        end else begin
                            st_reg    <= ST_OK;
                            state_reg <= S_WALK;
                        end
                    end else begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    idx_reg <= idx_reg + IW'(1);
                    if (ins_now || ins_reg) begin
                        hold_reg <= head;
                    end
                    if (ins_now) begin
                        ins_reg   <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                    end
                    case (req_reg.kind)
                        KIND_P2V: begin
                            if (!done_reg && valid_c) begin
                                if (head.start > req_reg.page) begin
                                    done_reg <= 1'b1;
                                end else if (end_c > {1'b0, req_reg.page}) begin
                                    res_reg  <= acc_reg + (req_reg.page - head.start);
                                    st_reg   <= ST_OK;
                                    done_reg <= 1'b1;
                                end else begin
                                    acc_reg <= acc_reg + head.length;
                                end
                            end
                        end
                        KIND_V2P: begin
                            if (!done_reg && valid_c) begin
                                if (head.length > req_reg.page - acc_reg) begin
                                    res_reg  <= head.start + (req_reg.page - acc_reg);
                                    st_reg   <= ST_OK;
                                    done_reg <= 1'b1;
                                end else begin
                                    acc_reg <= acc_reg + head.length;
                                end
                            end
                        end
                        KIND_NEXT: begin
                            if (want_reg) begin
                                want_reg <= 1'b0;
                                done_reg <= 1'b1;
                                if (valid_c) begin
                                    res_reg <= head.start;
                                    st_reg  <= ST_OK;
                                end else begin
                                    st_reg <= ST_NO_NEXT;
                                end
                            end else if (!done_reg && valid_c &&
                                         end_c > {1'b0, req_reg.page} &&
                                         head.start <= req_reg.page) begin
                                if ({1'b0, req_reg.page} < end_c - 53'd1) begin
                                    res_reg  <= req_reg.page + PAGE_W'(1);
                                    st_reg   <= ST_OK;
                                    done_reg <= 1'b1;
                                end else begin
                                    want_reg <= 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = (state_reg == S_DONE);
    assign m_data.status      = st_reg;
    assign m_data.result_page = (st_reg == ST_OK) ? res_reg : '0;

    // The table never grows past one below its capacity.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("region count above capacity");

    // The table grows by at most one region per cycle, only while walking.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) && $past(state_reg) == S_WALK))
        else $error("region count changed unexpectedly");

    // An add that walks the table inserts exactly once.
    a_insert_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && $past(state_reg) == S_WALK &&
         req_reg.kind == KIND_ADD) |-> ins_reg)
        else $error("add finished without inserting");

    // A result never waits while a new request is taken.
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

endmodule

### rtl/core/mrpt_cell.sv
module mrpt_cell
    import mrpt_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  entry_t d_in,
    output entry_t q
);

    entry_t entry_reg;

    // Each cell takes its neighbor's region while the ring turns.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= d_in;
        end
    end

    assign q = entry_reg;

endmodule

### test/memory_region_page_translator_unit_tb.sv
`timescale 1ns / 100ps

module memory_region_page_translator_unit_tb
    import mrpt_pkg::*;
;

    localparam int TABLE_DEPTH = 256;
    localparam logic [51:0] PAGE_ALL = {52{1'b1}};
    localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    memory_region_page_translator_unit #(.MAX_REGIONS(TABLE_DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow copy of the region table.
    logic [51:0] shadow_start [TABLE_DEPTH];
    logic [51:0] shadow_length [TABLE_DEPTH];
    int unsigned shadow_count;

    req_t pending_requests[$];
    rsp_t expected_results[$];
    int unsigned error_count;
    bit long_hold;
    longint unsigned cycle_count;
    logic s_ready_seen;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Compute the expected result of one request and update the shadow table.
    function automatic rsp_t translate_request(req_t rq);
        rsp_t r;
        logic [63:0] st, len, shard, acc, v, e, pos;
        logic [51:0] pg;
        bit done;
        r.result_page = '0;
        r.status = ST_NOT_FOUND;
        pg = rq.page;
        done = 0;
        case (rq.kind)
            KIND_ADD: begin
                if (shadow_count >= TABLE_DEPTH - 1) begin
                    r.status = ST_FULL;
                end else if (rq.region_type != TYPE_USABLE) begin
                    r.status = ST_SKIPPED;
                end else if (rq.base_address < LOW_MEMORY_END &&
                             rq.region_bytes <= LOW_MEMORY_END - rq.base_address) begin
                    r.status = ST_SKIPPED;
                end else begin
                    st = rq.base_address >> 12;
                    len = rq.region_bytes;
                    if (rq.base_address[11:0] != 12'd0) begin
                        shard = 64'h1000 - {52'd0, rq.base_address[11:0]};
                        if (len <= shard) begin
                            r.status = ST_SKIPPED;
                            done = 1;
                        end else begin
                            len = len - shard;
                            st = st + 64'd1;
                        end
                    end
                    if (!done) begin
                        len = len >> 12;
                        if (st <= 64'h100) begin
                            len = len + st;
                            st = '0;
                        end
                        st = st & {12'd0, PAGE_ALL};
                        len = len & {12'd0, PAGE_ALL};
                        pos = 64'(shadow_count);
                        for (int i = 0; i < shadow_count; i++) begin
                            if (shadow_start[i] > st[51:0]) begin
                                pos = 64'(i);
                                break;
                            end
                        end
                        for (int i = int'(shadow_count); i > pos; i--) begin
                            shadow_start[i] = shadow_start[i-1];
                            shadow_length[i] = shadow_length[i-1];
                        end
                        shadow_start[pos] = st[51:0];
                        shadow_length[pos] = len[51:0];
                        shadow_count++;
                        r.status = ST_OK;
                    end
                end
            end
            KIND_P2V: begin
                acc = '0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_start[i] > pg) break;
                    if ({12'd0, shadow_start[i]} + {12'd0, shadow_length[i]} >
                            {12'd0, pg}) begin
                        r.result_page = acc[51:0] + (pg - shadow_start[i]);
                        r.status = ST_OK;
                        break;
                    end
                    acc = acc + {12'd0, shadow_length[i]};
                end
            end
            KIND_V2P: begin
                v = {12'd0, pg};
                for (int i = 0; i < shadow_count; i++) begin
                    if ({12'd0, shadow_length[i]} > v) begin
                        r.result_page = shadow_start[i] + v[51:0];
                        r.status = ST_OK;
                        break;
                    end
                    v = v - {12'd0, shadow_length[i]};
                end
            end
            default: begin
                for (int i = 0; i < shadow_count; i++) begin
                    e = {12'd0, shadow_start[i]} + {12'd0, shadow_length[i]};
                    if (e > {12'd0, pg} && shadow_start[i] <= pg) begin
                        if ({12'd0, pg} < e - 64'd1) begin
                            r.result_page = pg + 52'd1;
                            r.status = ST_OK;
                        end else if (i + 1 >= shadow_count) begin
                            r.status = ST_NO_NEXT;
                        end else begin
                            r.result_page = shadow_start[i+1];
                            r.status = ST_OK;
                        end
                        break;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic req_t make_add(logic [63:0] b, logic [63:0] n, logic [7:0] t);
        req_t rq;
        rq.kind = KIND_ADD;
        rq.base_address = b;
        rq.region_bytes = n;
        rq.region_type = t;
        rq.page = 52'(rand64());
        return rq;
    endfunction

    function automatic req_t make_lookup(logic [1:0] k, logic [51:0] p);
        req_t rq;
        rq.kind = k;
        rq.base_address = rand64();
        rq.region_bytes = rand64();
        rq.region_type = 8'($urandom());
        rq.page = p;
        return rq;
    endfunction

    // Mostly small page numbers so that lookups land inside the table.
    function automatic logic [51:0] pick_page();
        case ($urandom_range(0, 5))
            0: return 52'(rand64());
            1: return 52'($urandom_range(0, 64));
            2: return PAGE_ALL - 52'($urandom_range(0, 3));
            default: return 52'($urandom_range(0, 'h4000));
        endcase
    endfunction

    function automatic req_t random_request();
        logic [63:0] b;
        logic [63:0] n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 4))
                    0: b = rand64();
                    1: b = 64'($urandom_range(0, 'h180000));
                    default: b = 64'({$urandom_range(0, 'h3fff), 12'h000}) +
                                 (($urandom_range(0, 3) == 0) ?
                                  64'($urandom_range(0, 'hfff)) : 64'd0);
                endcase
                case ($urandom_range(0, 4))
                    0: n = rand64();
                    1: n = 64'($urandom_range(0, 'h1fff));
                    default: n = 64'($urandom_range(0, 'h80000));
                endcase
                return make_add(b, n,
                                ($urandom_range(0, 5) == 0) ? 8'($urandom()) : TYPE_USABLE);
            end
            3, 4, 5: return make_lookup(KIND_P2V, pick_page());
            6, 7: return make_lookup(KIND_V2P, pick_page());
            default: return make_lookup(KIND_NEXT, pick_page());
        endcase
    endfunction

    // Driver: bursts of requests separated by random gaps.
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready_seen) begin
            // Hold the offered request.
        end else if (pending_requests.size() == 0) begin
            s_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid <= 1'b0;
        end else begin
            s_data <= pending_requests.pop_front();
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= int'($urandom_range(1, 12));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Acceptance at the rising edge, predicted in order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_ready_seen <= 1'b0;
        end else begin
            s_ready_seen <= s_valid && s_ready;
            if (s_valid && s_ready)
                expected_results.push_back(translate_request(s_data));
        end
    end

    // Receiver stall pattern with one long hold-off.
    int hold_cycles;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold) begin
            m_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 7))
                0, 1: m_ready <= 1'b0;
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result page=%h status=%0d",
                         $time, m_data.result_page, m_data.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    error_count++;
                end
                if (m_data.result_page !== want.result_page) begin
                    $display("%0t: result_page expected %h actual %h",
                             $time, want.result_page, m_data.result_page);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("memory_region_page_translator_unit regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering requests.
    initial begin
        long_hold = 1'b0;
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        long_hold = 1'b1;
        for (hold_cycles = 0; hold_cycles < 2000; hold_cycles++)
            @(posedge aclk);
        long_hold = 1'b0;
    end

    // Stimulus and end of run.
    initial begin
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        shadow_count = 0;

        // Lookups on an empty table, then filter cases and boundary regions.
        pending_requests.push_back(make_lookup(KIND_P2V, 52'h0));
        pending_requests.push_back(make_lookup(KIND_V2P, PAGE_ALL));
        pending_requests.push_back(make_lookup(KIND_NEXT, 52'h0));
        pending_requests.push_back(make_add(64'h200000, 64'h10000, 8'd2));
        pending_requests.push_back(make_add(64'h0, 64'h100000, TYPE_USABLE));
        pending_requests.push_back(make_add(64'h200800, 64'h800, TYPE_USABLE));
        pending_requests.push_back(make_add(64'h0, 64'h100001, TYPE_USABLE));
        pending_requests.push_back(make_add(64'h400fff, 64'h3001, TYPE_USABLE));
        pending_requests.push_back(make_add(64'h300000, 64'h800, TYPE_USABLE));
        pending_requests.push_back(make_add({64{1'b1}}, {64{1'b1}}, TYPE_USABLE));
        pending_requests.push_back(make_add(64'h0, {64{1'b1}}, 8'hff));
        pending_requests.push_back(make_add(64'h800000, 64'h8000, TYPE_USABLE));
        pending_requests.push_back(make_lookup(KIND_P2V, 52'h100));
        pending_requests.push_back(make_lookup(KIND_P2V, 52'h401));
        pending_requests.push_back(make_lookup(KIND_P2V, PAGE_ALL));
        pending_requests.push_back(make_lookup(KIND_V2P, 52'h0));
        pending_requests.push_back(make_lookup(KIND_V2P, 52'h101));
        pending_requests.push_back(make_lookup(KIND_NEXT, 52'h100));
        pending_requests.push_back(make_lookup(KIND_NEXT, 52'h403));
        pending_requests.push_back(make_lookup(KIND_NEXT, 52'h807));
        pending_requests.push_back(make_lookup(KIND_NEXT, PAGE_ALL));
        for (int i = 0; i < 1500; i++)
            pending_requests.push_back(random_request());
        // Fill the table to its limit to reach the full status.
        for (int i = 0; i < 260; i++)
            pending_requests.push_back(make_add(
                64'({$urandom_range(256, 'hfffff), 12'h0}), 64'h3000, TYPE_USABLE));
        for (int i = 0; i < 40; i++)
            pending_requests.push_back(random_request());

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_requests.size() == 0 && !s_valid);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TABLE_DEPTH + 20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("memory_region_page_translator_unit regression: pass");
        end else begin
            $display("memory_region_page_translator_unit regression: fail");
        end
        $finish;
    end

endmodule
